// File: src/sal_pkg.sv
// Shared constants and types for the shifting array list.
// Used by the request/result interfaces, the list cell and the top level.
package sal_pkg;

  // Default number of list entries.
  localparam int unsigned DepthDef = 64;

  // Field widths of one request word and one result word.
  localparam int unsigned ActW   = 2;
  localparam int unsigned PlaceW = 2;
  localparam int unsigned PosW   = 6;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 7;

  // Action codes.
  localparam logic [ActW-1:0] ActInsert = 2'd0;
  localparam logic [ActW-1:0] ActRemove = 2'd1;
  localparam logic [ActW-1:0] ActRead   = 2'd2;
  localparam logic [ActW-1:0] ActClear  = 2'd3;

  // Place codes.
  localparam logic [PlaceW-1:0] PlaceHead = 2'd0;
  localparam logic [PlaceW-1:0] PlaceTail = 2'd1;
  localparam logic [PlaceW-1:0] PlaceAt   = 2'd2;

  // Shift command broadcast to every cell in the row.
  typedef struct packed {
    logic ins;  // Insert at the target: cells above take their lower neighbor.
    logic rem;  // Remove at the target: cells from it on take their upper neighbor.
  } sal_op_t;

endpackage

// File: src/sal_req_if.sv
// Request channel of the shifting array list: valid/ready plus one request word.
// Depends on sal_pkg for the field widths.
interface sal_req_if;

  logic                            valid;
  logic                            ready;
  logic [sal_pkg::ActW-1:0]        action;
  logic [sal_pkg::PlaceW-1:0]      place;
  logic [sal_pkg::PosW-1:0]        position;
  logic signed [sal_pkg::DataW-1:0] value;

  modport source (output valid, action, place, position, value, input ready);
  modport sink   (input valid, action, place, position, value, output ready);

endinterface

// File: src/sal_rsp_if.sv
// Result channel of the shifting array list: valid/ready plus one result word.
// Depends on sal_pkg for the field widths.
interface sal_rsp_if;

  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic signed [sal_pkg::DataW-1:0] element;
  logic [sal_pkg::CountW-1:0]       count;

  modport source (output valid, ok, element, count, input ready);
  modport sink   (input valid, ok, element, count, output ready);

endinterface

// File: src/sal_cell.sv
// One entry of the list: holds a value and shifts with its neighbors.
// Depends on sal_pkg for the shift command type and the data width.
module sal_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CmpW  = 7
) (
  input  logic                      clk_i,
  input  sal_pkg::sal_op_t          op_i,
  input  logic [CmpW-1:0]           tgt_i,
  input  logic [sal_pkg::DataW-1:0] value_i,
  input  logic [sal_pkg::DataW-1:0] lower_i,
  input  logic [sal_pkg::DataW-1:0] upper_i,
  output logic [sal_pkg::DataW-1:0] data_o,
  output logic [sal_pkg::DataW-1:0] sel_data_o
);

  localparam logic [CmpW-1:0] MyIdx = CmpW'(Index);

  logic [sal_pkg::DataW-1:0] data_d, data_q;
  logic                      hit, above;

  assign hit   = (tgt_i == MyIdx);
  assign above = (MyIdx > tgt_i);

  // Next value: new word at the target on insert, neighbor data when shifting.
  always_comb begin
    data_d = data_q;
    if (op_i.ins) begin
      if (hit) begin
        data_d = value_i;
      end else if (above) begin
        data_d = lower_i;
      end
    end else if (op_i.rem) begin
      if (hit || above) begin
        data_d = upper_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  // Only the targeted cell drives its word onto the read bus.
  assign sel_data_o = hit ? data_q : '0;

endmodule

// File: src/shifting_array_list.sv
// Shifting array list: an ordered list of up to Depth signed 32-bit words.
// Uses sal_pkg, sal_req_if, sal_rsp_if and a row of sal_cell entries.
//
// Usage:
//   req_i carries one request word: action (insert, remove, read, clear),
//   place (head, tail, given position), position and the value to insert.
//   rsp_o returns one result word per request: ok, the element removed or
//   read (zero otherwise) and the entry count after the request.
//   Each entry sits in its own cell; an insert or remove updates the target
//   cell and every cell above it together.
// Result timing and throughput:
//   The result word is registered and appears in the cycle after the request is accepted.
//   One request is taken per cycle as long as the result side keeps up; the
//   read path is one compare per cell and an OR over all cells.
// Reset:
//   rst_ni clears the entry count and the output valid; entry contents are
//   not cleared and are never read before being written.
// Stall:
//   While a result word waits and rsp_o.ready is low, req_i.ready is low and
//   the list state holds. A new request is taken in the cycle the waiting
//   result word is taken.
module shifting_array_list #(
  parameter int unsigned Depth = sal_pkg::DepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sal_req_if.sink   req_i,
  sal_rsp_if.source rsp_o
);

  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam int unsigned CmpW  = (FillW > sal_pkg::PosW) ? FillW : sal_pkg::PosW;
  localparam int unsigned ExtW  = (FillW > sal_pkg::CountW) ? FillW : sal_pkg::CountW;
  localparam logic [CmpW-1:0] DepthC = CmpW'(Depth);

  logic [FillW-1:0] fill_d, fill_q;
  logic [CmpW-1:0]  fill_c, tgt;
  logic             place_ok, ins_ok, rd_ok, accept;
  sal_pkg::sal_op_t op;

  logic [sal_pkg::DataW-1:0] cell_data [Depth];
  logic [sal_pkg::DataW-1:0] cell_sel  [Depth];
  logic [sal_pkg::DataW-1:0] rd_word;

  logic                      rsp_valid_q;
  logic                      rsp_ok_d, rsp_ok_q;
  logic [sal_pkg::DataW-1:0] rsp_elem_d, rsp_elem_q;
  logic [ExtW-1:0]           fill_ext;

  // A new request is taken when the output register is free or being emptied.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign fill_c = CmpW'(fill_q);

  // Resolve the target index from the place code.
  always_comb begin
    place_ok = 1'b1;
    tgt      = '0;
    case (req_i.place)
      sal_pkg::PlaceHead: tgt = '0;
      sal_pkg::PlaceTail: tgt = (req_i.action == sal_pkg::ActInsert) ? fill_c : fill_c - 1'b1;
      sal_pkg::PlaceAt:   tgt = CmpW'(req_i.position);
      default:            place_ok = 1'b0;
    endcase
  end

  // Bounds checks for insert and for remove or read.
  assign ins_ok = (req_i.action == sal_pkg::ActInsert) && (fill_c < DepthC) &&
                  place_ok && (tgt <= fill_c);
  assign rd_ok  = ((req_i.action == sal_pkg::ActRemove) ||
                   (req_i.action == sal_pkg::ActRead)) &&
                  (fill_q != '0) && place_ok && (tgt < fill_c);

  assign op.ins = accept && ins_ok;
  assign op.rem = accept && rd_ok && (req_i.action == sal_pkg::ActRemove);

  // Row of cells; the top cell keeps its own word on a remove.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [sal_pkg::DataW-1:0] lower, upper;
    if (i == 0) begin : g_first
      assign lower = req_i.value;
    end else begin : g_mid
      assign lower = cell_data[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_body
      assign upper = cell_data[i+1];
    end
    sal_cell #(
      .Index(i),
      .CmpW (CmpW)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (op),
      .tgt_i     (tgt),
      .value_i   (req_i.value),
      .lower_i   (lower),
      .upper_i   (upper),
      .data_o    (cell_data[i]),
      .sel_data_o(cell_sel[i])
    );
  end

  // Read bus: at most one cell drives a nonzero word.
  always_comb begin
    rd_word = '0;
    for (int unsigned k = 0; k < Depth; k++) begin
      rd_word = rd_word | cell_sel[k];
    end
  end

  // Next count and result word.
  always_comb begin
    fill_d     = fill_q;
    rsp_ok_d   = 1'b0;
    rsp_elem_d = '0;
    if (req_i.action == sal_pkg::ActClear) begin
      fill_d   = '0;
      rsp_ok_d = 1'b1;
    end else if (ins_ok) begin
      fill_d   = fill_q + 1'b1;
      rsp_ok_d = 1'b1;
    end else if (rd_ok) begin
      rsp_ok_d   = 1'b1;
      rsp_elem_d = rd_word;
      if (req_i.action == sal_pkg::ActRemove) begin
        fill_d = fill_q - 1'b1;
      end
    end
  end

  // Control state: count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q <= fill_d;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_ok_q   <= rsp_ok_d;
      rsp_elem_q <= rsp_elem_d;
    end
  end

  assign fill_ext      = ExtW'(fill_q);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.ok      = rsp_ok_q;
  assign rsp_o.element = rsp_elem_q;
  assign rsp_o.count   = fill_ext[sal_pkg::CountW-1:0];

endmodule

// File: verif/shifting_array_list_test.sv
// Self-checking testbench for the shifting array list (shifting_array_list).
// Depends on sal_pkg, sal_req_if, sal_rsp_if and the list RTL; a scoreboard
// class mirrors the list contents and checks every result word in order.
`timescale 1ns / 100ps

module shifting_array_list_test;
  import sal_pkg::*;

  localparam int unsigned ListDepth   = DepthDef;
  localparam int unsigned RandomWords = 600;
  localparam int unsigned GrowWords   = 140;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned IdlePercent = 27;

  // Place code the block does not define; every insert, remove or read using it must fail.
  localparam logic [PlaceW-1:0] PlaceUnused = 2'd3;

  // Action mixes used by the random phases.
  typedef enum int unsigned {
    MixGrow,
    MixShrink,
    MixEven
  } op_mix_e;

  typedef struct packed {
    logic [ActW-1:0]          action;
    logic [PlaceW-1:0]        place;
    logic [PosW-1:0]          position;
    logic signed [DataW-1:0]  value;
  } list_req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DataW-1:0]  element;
    logic [CountW-1:0]        count;
  } list_rsp_t;

  // Mirror of the list plus the queue of result words still owed by the block.
  class list_scoreboard;
    logic signed [DataW-1:0] mirror_entries [ListDepth];
    int unsigned             mirror_fill;
    list_rsp_t               due_results [$];
    int unsigned             errors;

    function new();
      mirror_fill = 0;
      errors = 0;
    endfunction

    // Apply one accepted request to the mirror and queue the result it owes.
    function void note_request(list_req_t r);
      list_rsp_t   res;
      int unsigned idx;
      int unsigned i;
      bit          placed;
      res = '0;
      idx = 0;
      placed = 1'b1;
      case (r.place)
        PlaceHead: idx = 0;
        PlaceTail: idx = (r.action == ActInsert || mirror_fill == 0) ? mirror_fill
                                                                      : mirror_fill - 1;
        PlaceAt:   idx = 32'(r.position);
        default:   placed = 1'b0;
      endcase
      if (r.action == ActClear) begin
        mirror_fill = 0;
        res.ok = 1'b1;
      end else if (r.action == ActInsert) begin
        // A position equal to the count appends; anything past it fails.
        if (mirror_fill < ListDepth && placed && idx <= mirror_fill) begin
          for (i = mirror_fill; i > idx; i--) begin
            mirror_entries[i] = mirror_entries[i-1];
          end
          mirror_entries[idx] = r.value;
          mirror_fill++;
          res.ok = 1'b1;
        end
      end else begin
        // Remove and read only touch entries below the count.
        if (mirror_fill > 0 && placed && idx < mirror_fill) begin
          res.element = mirror_entries[idx];
          if (r.action == ActRemove) begin
            for (i = idx; i + 1 < mirror_fill; i++) begin
              mirror_entries[i] = mirror_entries[i+1];
            end
            mirror_fill--;
          end
          res.ok = 1'b1;
        end
      end
      res.count = CountW'(mirror_fill);
      due_results.push_back(res);
    endfunction

    // Compare one accepted result word with the oldest owed result.
    function void check_result(list_rsp_t got);
      list_rsp_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: ok %0b element %0d count %0d",
                 $time, got.ok, got.element, got.count);
        return;
      end
      want = due_results.pop_front();
      if (got.ok !== want.ok) begin
        errors++;
        $display("%0t: ok mismatch: expected %0b, actual %0b", $time, want.ok, got.ok);
      end
      if (got.element !== want.element) begin
        errors++;
        $display("%0t: element mismatch: expected %0d, actual %0d",
                 $time, want.element, got.element);
      end
      if (got.count !== want.count) begin
        errors++;
        $display("%0t: count mismatch: expected %0d, actual %0d",
                 $time, want.count, got.count);
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           idle_on;
  int unsigned    quiet_cycles;
  list_scoreboard board;

  sal_req_if req_bus ();
  sal_rsp_if rsp_bus ();

  shifting_array_list #(
    .Depth(ListDepth)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Clock with a 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Result side: stall at random while idling is enabled.
  always @(negedge clk_i) begin
    rsp_bus.ready <= !idle_on || ($urandom_range(99) >= IdlePercent);
  end

  // Watch both channels, feed the scoreboard and guard against a hang.
  always @(posedge clk_i) begin
    list_req_t seen_req;
    list_rsp_t seen_rsp;
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        seen_rsp.ok = rsp_bus.ok;
        seen_rsp.element = rsp_bus.element;
        seen_rsp.count = rsp_bus.count;
        board.check_result(seen_rsp);
      end
      if (req_bus.valid && req_bus.ready) begin
        seen_req.action = req_bus.action;
        seen_req.place = req_bus.place;
        seen_req.position = req_bus.position;
        seen_req.value = req_bus.value;
        board.note_request(seen_req);
      end
      if ((rsp_bus.valid && rsp_bus.ready) || (req_bus.valid && req_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one request word, with a random gap first, until it is taken.
  // Called at a falling edge and returns at a falling edge.
  task automatic send_word(input logic [ActW-1:0] action, input logic [PlaceW-1:0] place,
                           input logic [PosW-1:0] position,
                           input logic signed [DataW-1:0] value);
    while (idle_on && $urandom_range(99) < IdlePercent) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.action <= action;
    req_bus.place <= place;
    req_bus.position <= position;
    req_bus.value <= value;
    do @(posedge clk_i); while (!req_bus.ready);
    @(negedge clk_i);
  endtask

  // Hold off new requests until every owed result word has come back.
  task automatic wait_for_results();
    req_bus.valid <= 1'b0;
    while (board.due_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Mostly well-formed requests aimed at the current count, with some noise.
  task automatic send_random(input op_mix_e mix);
    int unsigned             roll;
    int unsigned             ins_w;
    int unsigned             rem_w;
    int unsigned             read_w;
    int unsigned             top;
    logic [ActW-1:0]         action;
    logic [PlaceW-1:0]       place;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
    case (mix)
      MixGrow:   begin ins_w = 80; rem_w = 12; read_w = 6;  end
      MixShrink: begin ins_w = 15; rem_w = 65; read_w = 18; end
      default:   begin ins_w = 40; rem_w = 30; read_w = 27; end
    endcase
    roll = $urandom_range(99);
    if (roll < ins_w) begin
      action = ActInsert;
    end else if (roll < ins_w + rem_w) begin
      action = ActRemove;
    end else if (roll < ins_w + rem_w + read_w) begin
      action = ActRead;
    end else begin
      action = ActClear;
    end

    roll = $urandom_range(99);
    if (roll < 5) begin
      place = PlaceUnused;
    end else if (roll < 35) begin
      place = PlaceHead;
    end else if (roll < 65) begin
      place = PlaceTail;
    end else begin
      place = PlaceAt;
    end

    // Positions mostly inside the valid range; a fifth anywhere in the field.
    if (action == ActInsert) begin
      top = board.mirror_fill;
    end else begin
      top = (board.mirror_fill > 0) ? board.mirror_fill - 1 : 0;
    end
    if (top > 63) begin
      top = 63;
    end
    if ($urandom_range(99) < 20) begin
      position = PosW'($urandom_range(63));
    end else begin
      position = PosW'($urandom_range(top));
    end

    if ($urandom_range(99) < 10) begin
      case ($urandom_range(3))
        0:       value = 32'sh7FFF_FFFF;
        1:       value = 32'sh8000_0000;
        2:       value = '0;
        default: value = -32'sd1;
      endcase
    end else begin
      value = $urandom;
    end
    send_word(action, place, position, value);
  endtask

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned span;
    int unsigned k;
    op_mix_e     mix;
    board = new();
    quiet_cycles = 0;
    idle_on = 1'b1;
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.action = ActInsert;
    req_bus.place = PlaceHead;
    req_bus.position = '0;
    req_bus.value = '0;
    rsp_bus.ready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words: empty list, bounds, unused place code, extremes, clear.
    send_word(ActRead,   PlaceHead,   6'd5,  32'sd0);
    send_word(ActRemove, PlaceTail,   6'd0,  32'sd0);
    send_word(ActRead,   PlaceAt,     6'd0,  32'sd0);
    send_word(ActInsert, PlaceAt,     6'd1,  32'sd11);
    send_word(ActInsert, PlaceAt,     6'd0,  32'sh7FFF_FFFF);
    send_word(ActInsert, PlaceHead,   6'd63, 32'sh8000_0000);
    send_word(ActInsert, PlaceTail,   6'd42, -32'sd1);
    send_word(ActInsert, PlaceAt,     6'd3,  32'sd0);
    send_word(ActInsert, PlaceAt,     6'd63, 32'sh5555_AAAA);
    send_word(ActInsert, PlaceUnused, 6'd0,  32'sd7);
    send_word(ActRead,   PlaceUnused, 6'd0,  32'sd0);
    send_word(ActRemove, PlaceUnused, 6'd0,  32'sd0);
    send_word(ActRead,   PlaceAt,     6'd3,  32'sd0);
    send_word(ActRead,   PlaceAt,     6'd4,  32'sd0);
    send_word(ActRead,   PlaceHead,   6'd21, 32'sd0);
    send_word(ActRead,   PlaceTail,   6'd0,  32'sd0);
    send_word(ActRemove, PlaceAt,     6'd1,  32'sd0);
    send_word(ActRemove, PlaceAt,     6'd63, 32'sd0);
    send_word(ActRemove, PlaceHead,   6'd9,  32'sd0);
    send_word(ActRemove, PlaceTail,   6'd0,  32'sd0);
    send_word(ActInsert, PlaceTail,   6'd0,  32'sh2AAA_5555);
    send_word(ActClear,  PlaceUnused, 6'd63, 32'sh1234_5678);
    send_word(ActRead,   PlaceTail,   6'd0,  32'sd0);
    send_word(ActClear,  PlaceHead,   6'd0,  32'sd0);
    wait_for_results();

    // Random phases: the first fills the list past full, the rest vary.
    // A stretch in the middle runs with no idling on either side.
    sent = 0;
    phase = 0;
    while (sent < RandomWords) begin
      if (phase == 0) begin
        mix = MixGrow;
        span = GrowWords;
      end else begin
        mix = op_mix_e'($urandom_range(2));
        span = $urandom_range(90, 40);
      end
      for (k = 0; k < span && sent < RandomWords; k++) begin
        idle_on <= !(sent >= 250 && sent < 400);
        send_random(mix);
        sent++;
      end
      wait_for_results();
      phase++;
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/sal_pkg.sv
src/sal_req_if.sv
src/sal_rsp_if.sv
src/sal_cell.sv
src/shifting_array_list.sv
verif/shifting_array_list_test.sv
